FILE: rtl/spg_pkg.sv
package spg_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int PW_W            = 16;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [PW_W-1:0] HIGH_TICKS_RST = 16'd5;

    // register index, taken from paddr word bit
    localparam logic REG_HIGH_TICKS = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FIELD_W-1:0] step_count;
        logic [FIELD_W-1:0] step_period;
    } t_in_item;

    typedef struct packed {
        logic step_level;
        logic busy_res;
        logic status;
        logic run_done;
    } t_out_item;

endpackage

FILE: rtl/spg_apb.sv
module spg_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [spg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [spg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [spg_pkg::PW_W-1:0]            o_high_ticks
);
    import spg_pkg::*;

    logic [PW_W-1:0] r_high_ticks;
    logic [PW_W-1:0] n_high_ticks;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_high_ticks = r_high_ticks;
        prdata       = '0;
        unique case (paddr[2])
            REG_HIGH_TICKS: begin
                prdata = APB_DATA_W'(r_high_ticks);
                if (w_wr) begin
                    n_high_ticks = pwdata[PW_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_ticks <= HIGH_TICKS_RST;
        end else begin
            r_high_ticks <= n_high_ticks;
        end
    end

    assign o_high_ticks = r_high_ticks;

endmodule

FILE: rtl/spg_core.sv
module spg_core #(
    parameter int COUNT_WIDTH = spg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  spg_pkg::t_in_item         i_item,
    input  logic [spg_pkg::PW_W-1:0]  i_high_ticks,
    output spg_pkg::t_out_item        o_result
);
    import spg_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > PW_W) ? CW : PW_W;

    logic          r_running,  n_running;
    logic          r_line_high, n_line_high;
    logic [CW-1:0] r_pulses_left, n_pulses_left;
    logic [CW-1:0] r_period_held, n_period_held;
    logic [CW-1:0] r_ticks_to_edge, n_ticks_to_edge;

    logic [CW-1:0]    w_count;
    logic [CW-1:0]    w_period;
    logic [CW-1:0]    w_pw_cnt;
    logic [CMP_W-1:0] w_pw_cmp;
    logic [CMP_W-1:0] w_period_cmp;
    logic [CMP_W-1:0] w_held_cmp;
    logic [CW-1:0]    w_low_time;
    logic [CW-1:0]    w_pl_dec;
    logic             w_reject;
    logic             w_status;
    logic             w_done;

    assign w_count      = i_item.step_count[CW-1:0];
    assign w_period     = i_item.step_period[CW-1:0];
    assign w_pw_cnt     = CW'(i_high_ticks);
    assign w_pw_cmp     = CMP_W'(i_high_ticks);
    assign w_period_cmp = CMP_W'(w_period);
    assign w_held_cmp   = CMP_W'(r_period_held);
    assign w_reject     = (w_count == '0) || (w_period_cmp <= w_pw_cmp);
    // low time floors at one tick if the width was raised to or past the period
    assign w_low_time   = (w_held_cmp > w_pw_cmp) ? CW'(w_held_cmp - w_pw_cmp) : CW'(1);
    assign w_pl_dec     = (r_pulses_left != '0) ? (r_pulses_left - CW'(1)) : r_pulses_left;

    always_comb begin
        n_running       = r_running;
        n_line_high     = r_line_high;
        n_pulses_left   = r_pulses_left;
        n_period_held   = r_period_held;
        n_ticks_to_edge = r_ticks_to_edge;
        w_status        = 1'b0;
        w_done          = 1'b0;
        if (i_step) begin
            case (i_item.operation)
                OP_TICK: begin
                    if (r_running) begin
                        if (r_ticks_to_edge > CW'(1)) begin
                            n_ticks_to_edge = r_ticks_to_edge - CW'(1);
                        end else if (!r_line_high) begin
                            n_line_high     = 1'b1;
                            n_ticks_to_edge = w_pw_cnt;
                        end else begin
                            n_line_high   = 1'b0;
                            n_pulses_left = w_pl_dec;
                            if (w_pl_dec == '0) begin
                                n_running       = 1'b0;
                                n_ticks_to_edge = '0;
                                w_done          = 1'b1;
                            end else begin
                                n_ticks_to_edge = w_low_time;
                            end
                        end
                    end
                end
                OP_START: begin
                    if (w_reject) begin
                        w_status = 1'b1;
                    end else begin
                        n_pulses_left   = w_count;
                        n_period_held   = w_period;
                        n_line_high     = 1'b0;
                        n_running       = 1'b1;
                        n_ticks_to_edge = w_pw_cnt;
                    end
                end
                OP_STOP: begin
                    n_running       = 1'b0;
                    n_line_high     = 1'b0;
                    n_pulses_left   = '0;
                    n_ticks_to_edge = '0;
                end
                default: begin
                    n_running = r_running;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running       <= 1'b0;
            r_line_high     <= 1'b0;
            r_pulses_left   <= '0;
            r_period_held   <= '0;
            r_ticks_to_edge <= '0;
        end else begin
            r_running       <= n_running;
            r_line_high     <= n_line_high;
            r_pulses_left   <= n_pulses_left;
            r_period_held   <= n_period_held;
            r_ticks_to_edge <= n_ticks_to_edge;
        end
    end

    assign o_result.step_level = n_line_high;
    assign o_result.busy_res   = n_running;
    assign o_result.status     = w_status;
    assign o_result.run_done   = w_done;

`ifndef SYNTH
    a_line_only_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running || !r_line_high))
        else $error("step line high with no run in progress");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_done) |=> (!r_running && !r_line_high && r_pulses_left == '0))
        else $error("run still active after final edge");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_status) |=> ($stable(r_running) && $stable(r_pulses_left)
            && $stable(r_period_held) && $stable(r_ticks_to_edge)))
        else $error("rejected start changed run state");
`endif

endmodule

FILE: rtl/step_pulse_train_generator.sv
// Datapath: an accepted item is held in the input register; its result is then
//   registered into the output register once that is free, which raises o_out_valid.
// Throughput: one item per cycle while i_out_ready keeps the output free; the input
//   and result registers let a new item in while a result waits for i_out_ready.
// Reset (synchronous, active low): run idle, line low, counters zero, high time 5 ticks.
module step_pulse_train_generator #(
    parameter int COUNT_WIDTH = spg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  spg_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output spg_pkg::t_out_item                  o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [spg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [spg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import spg_pkg::*;

    logic            r_in_valid;
    t_in_item        r_in_item;
    logic            r_out_valid;
    t_out_item       r_out_item;
    logic            w_out_free;
    logic            w_adv;
    logic [PW_W-1:0] w_high_ticks;
    t_out_item       w_result;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    spg_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_high_ticks (w_high_ticks)
    );

    spg_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_item       (r_in_item),
        .i_high_ticks (w_high_ticks),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_adv) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
